>>> design/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants of the multi-tap echo block.
// ----------------------------------------------------------------------------
`default_nettype none

package mte_pkg;

  typedef logic signed [15:0] sample_t;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ECHOES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN   = 2'd3;

  localparam logic [1:0]  RST_NUM_CHANNELS = 2'd1;
  localparam logic [12:0] RST_BASE_DELAY   = 13'd1024;
  localparam logic [3:0]  RST_NUM_ECHOES   = 4'd3;
  localparam logic [14:0] RST_DECAY_GAIN   = 15'd16384;

  // decay limits in Q0.15 (0.1 and 0.9)
  localparam logic [14:0] DECAY_MIN = 15'd3277;
  localparam logic [14:0] DECAY_MAX = 15'd29491;

  // one half in Q0.15, added before dropping 15 fraction bits: round half up
  localparam logic [14:0] ROUND_HALF = 15'd16384;

  // accumulator: dry * 2^15 plus up to fifteen weighted taps (four-bit echo count)
  localparam int ACC_W = 40;
  localparam int RES_W = ACC_W - 15;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = -16'sh8000;

  typedef struct packed {
    logic start;   // load first echo distance
    logic rd_en;   // read one tap and step the distance
    logic wr_en;   // store the dry word and advance the write position
  } ring_ctl_t;

  typedef struct packed {
    logic start;   // load dry sample and first weight
    logic step;    // one tap read issued this cycle
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> design/mte_if.sv
// ----------------------------------------------------------------------------
// mte_if
// Valid/ready channels for input and result words of the multi-tap echo.
// ----------------------------------------------------------------------------
`default_nettype none

interface mte_in_if import mte_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    channel;

  modport source (output valid, output sample_in, output channel, input ready);
  modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

interface mte_out_if import mte_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

>>> design/multi_tap_echo.sv
// ----------------------------------------------------------------------------
// multi_tap_echo
// Multi-tap delay echo with exponentially decaying taps per channel.
// ----------------------------------------------------------------------------
// Input words (sample_in, channel) arrive on in_i, one result word per input
// leaves on out_o; both are valid/ready. Registers are written on the cfg
// port (index 0 channels, 1 base delay, 2 echo count, 3 decay); the user must
// write them only while the block is idle, as the block itself does not
// enforce it; cfg_ready_o is always high.
// A word for a channel in use needs one tap read per echo (echo count clamped
// to 1..MAX_TAPS) through the single read port of the ring memory: one tap
// read per cycle, followed by the product and accumulate stages. A word for
// a channel not in use passes through dry; the rings are untouched. In both
// cases the next word is taken only once the result is registered.
// After reset the write positions are zero and every ring reads as silence:
// a wrapped flag per channel masks entries not yet written, so there is no
// clearing pass. A stalled receiver holds the result in the output
// register; one further word is accepted and then waits until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_tap_echo import mte_pkg::*; #(
  parameter int MAX_TAPS   = 8,
  parameter int RING_DEPTH = 32768,
  parameter int CHANNELS   = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mte_in_if.sink                     in_i,
  mte_out_if.source                  out_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PW   = $clog2(RING_DEPTH + 1);
  localparam int TW   = $clog2(MAX_TAPS + 1);
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SPC_MAX = RING_DEPTH / MAX_TAPS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [1:0]    num_channels_q;
  logic [12:0]   base_delay_q;
  logic [3:0]    num_echoes_q;
  logic [14:0]   decay_gain_q;
  sample_t       dry_q;
  logic          ch_q;
  logic          pass_q;
  logic [TW-1:0] taps_q;
  logic [TW-1:0] cnt_q;
  logic          out_vld_q;
  sample_t       out_sample_q;
  logic          out_clip_q;

  logic [3:0]    chans;
  logic          in_use;
  logic [PW-1:0] spacing;
  logic [TW-1:0] taps;
  logic [14:0]   decay;
  logic          in_acc;
  logic          out_free;
  logic          finish;
  ring_ctl_t     ring_ctl;
  mac_ctl_t      mac_ctl;
  sample_t       rdata;
  logic          mac_busy;
  sample_t       mac_sample;
  logic          mac_clip;

  // register clamps
  always_comb begin
    if (num_channels_q == 2'd0) begin
      chans = 4'd1;
    end else if (4'(num_channels_q) > 4'(CHANNELS)) begin
      chans = 4'(CHANNELS);
    end else begin
      chans = 4'(num_channels_q);
    end

    if (base_delay_q == 13'd0) begin
      spacing = PW'(1);
    end else if (32'(base_delay_q) > 32'(SPC_MAX)) begin
      spacing = PW'(SPC_MAX);
    end else begin
      spacing = PW'(base_delay_q);
    end

    if (num_echoes_q == 4'd0) begin
      taps = TW'(1);
    end else if (32'(num_echoes_q) > 32'(MAX_TAPS)) begin
      taps = TW'(MAX_TAPS);
    end else begin
      taps = TW'(num_echoes_q);
    end

    if (decay_gain_q < DECAY_MIN) begin
      decay = DECAY_MIN;
    end else if (decay_gain_q > DECAY_MAX) begin
      decay = DECAY_MAX;
    end else begin
      decay = decay_gain_q;
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign in_use      = {3'b000, in_i.channel} < chans;
  assign out_free    = !out_vld_q || out_o.ready;
  assign finish      = (state_q == ST_DRAIN) && !mac_busy && out_free;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ring_ctl.start = in_acc;
    ring_ctl.rd_en = (state_q == ST_RUN);
    ring_ctl.wr_en = finish && !pass_q;
    mac_ctl.start  = in_acc;
    mac_ctl.step   = (state_q == ST_RUN);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = in_use ? ST_RUN : ST_DRAIN;
        end
      end
      ST_RUN: begin
        if (cnt_q == taps_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_vld_q      <= 1'b0;
      num_channels_q <= RST_NUM_CHANNELS;
      base_delay_q   <= RST_BASE_DELAY;
      num_echoes_q   <= RST_NUM_ECHOES;
      decay_gain_q   <= RST_DECAY_GAIN;
      cnt_q          <= '0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (in_acc) begin
        cnt_q <= TW'(1);
      end else if (state_q == ST_RUN) begin
        cnt_q <= cnt_q + TW'(1);
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_NUM_CHANNELS: num_channels_q <= cfg_data_i[1:0];
          REG_BASE_DELAY:   base_delay_q   <= cfg_data_i[12:0];
          REG_NUM_ECHOES:   num_echoes_q   <= cfg_data_i[3:0];
          REG_DECAY_GAIN:   decay_gain_q   <= cfg_data_i[14:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dry_q  <= in_i.sample_in;
      ch_q   <= in_i.channel;
      pass_q <= !in_use;
      taps_q <= taps;
    end
    if (finish) begin
      out_sample_q <= pass_q ? dry_q : mac_sample;
      out_clip_q   <= pass_q ? 1'b0 : mac_clip;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.clipped    = out_clip_q;

  mte_ring #(
    .RING_DEPTH (RING_DEPTH),
    .CHANNELS   (CHANNELS)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ring_ctl),
    .ch_i      (CH_W'(ch_q)),
    .spacing_i (spacing),
    .wdata_i   (dry_q),
    .rdata_o   (rdata)
  );

  mte_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .dry_i    (in_i.sample_in),
    .decay_i  (decay),
    .rdata_i  (rdata),
    .busy_o   (mac_busy),
    .sample_o (mac_sample),
    .clip_o   (mac_clip)
  );

endmodule

`default_nettype wire

>>> design/mte_ring.sv
// ----------------------------------------------------------------------------
// mte_ring
// Per-channel delay rings in one synchronous memory, with write positions
// and a wrapped flag per channel so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_ring import mte_pkg::*; #(
  parameter int RING_DEPTH = 32768,
  parameter int CHANNELS   = 2,
  localparam int AW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int PW        = $clog2(RING_DEPTH + 1),
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ring_ctl_t       ctl_i,
  input  wire logic [CH_W-1:0] ch_i,
  input  wire logic [PW-1:0]   spacing_i,
  input  wire sample_t         wdata_i,
  output sample_t              rdata_o
);

  localparam int MEM_DEPTH = CHANNELS << AW;
  localparam logic [PW:0] RD_L = (PW+1)'(RING_DEPTH);

  logic [15:0]   mem_q [MEM_DEPTH];
  logic [AW-1:0] pos_q [CHANNELS];
  logic          wrap_q [CHANNELS];
  logic [PW-1:0] back_q;
  logic [15:0]   raw_q;
  logic          ok_q;

  logic [AW-1:0] pos;
  logic [PW-1:0] pos_ext;
  logic [PW:0]   diff_dir;
  logic [PW:0]   diff_wrap;
  logic [AW-1:0] rd;
  logic          ok;
  logic          pos_last;
  logic [AW-1:0] pos_nxt;

  always_comb begin
    pos       = pos_q[ch_i];
    pos_ext   = PW'(pos);
    diff_dir  = {1'b0, pos_ext} - {1'b0, back_q};
    diff_wrap = {1'b0, pos_ext} + RD_L - {1'b0, back_q};
    if (pos_ext >= back_q) begin
      rd = diff_dir[AW-1:0];
    end else begin
      rd = diff_wrap[AW-1:0];
    end
    // entries are filled in order from position zero
    ok       = wrap_q[ch_i] || (rd < pos);
    pos_last = (pos == AW'(RING_DEPTH - 1));
    pos_nxt  = pos_last ? '0 : pos + AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[{ch_i, pos}] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      raw_q <= mem_q[{ch_i, rd}];
    end
    if (ctl_i.start) begin
      back_q <= spacing_i;
    end else if (ctl_i.rd_en) begin
      back_q <= back_q + spacing_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i]  <= '0;
        wrap_q[i] <= 1'b0;
      end
      ok_q <= 1'b0;
    end else begin
      if (ctl_i.rd_en) begin
        ok_q <= ok;
      end
      if (ctl_i.wr_en) begin
        pos_q[ch_i] <= pos_nxt;
        if (pos_last) begin
          wrap_q[ch_i] <= 1'b1;
        end
      end
    end
  end

  assign rdata_o = ok_q ? sample_t'(raw_q) : '0;

endmodule

`default_nettype wire

>>> design/mte_mac.sv
// ----------------------------------------------------------------------------
// mte_mac
// Tap weighting and accumulation: decay powers by repeated Q0.15 products,
// one weighted tap per cycle, then round half up and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_mac import mte_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire mac_ctl_t    ctl_i,
  input  wire sample_t     dry_i,
  input  wire logic [14:0] decay_i,
  input  wire sample_t     rdata_i,
  output logic             busy_o,
  output sample_t          sample_o,
  output logic             clip_o
);

  logic [14:0]              w_q;
  logic [14:0]              w_s1_q;
  logic                     s1_vld_q;
  logic                     s2_vld_q;
  logic signed [31:0]       prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [29:0]              wprod;
  logic [30:0]              wsum;
  logic signed [31:0]       prod_d;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RES_W-1:0]  res;

  always_comb begin
    wprod  = w_q * decay_i;
    wsum   = {1'b0, wprod} + 31'(ROUND_HALF);
    prod_d = $signed(rdata_i) * $signed({1'b0, w_s1_q});
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      w_q   <= decay_i;
      acc_q <= {{(ACC_W-31){dry_i[15]}}, dry_i, 15'd0};
    end else begin
      if (ctl_i.step) begin
        w_q <= wsum[29:15];
      end
      if (s2_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    if (ctl_i.step) begin
      w_s1_q <= w_q;
    end
    if (s1_vld_q) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= ctl_i.step;
      s2_vld_q <= s1_vld_q;
    end
  end

  assign busy_o = s1_vld_q | s2_vld_q;

  always_comb begin
    acc_r = acc_q + ACC_W'(ROUND_HALF);
    res   = acc_r[ACC_W-1:15];
    if (res > RES_W'(SAMPLE_MAX)) begin
      sample_o = SAMPLE_MAX;
      clip_o   = 1'b1;
    end else if (res < RES_W'(SAMPLE_MIN)) begin
      sample_o = SAMPLE_MIN;
      clip_o   = 1'b1;
    end else begin
      sample_o = res[15:0];
      clip_o   = 1'b0;
    end
  end

endmodule

`default_nettype wire
